[hdl/tick_to_ohlcv_bar_aggregator_core_macros.svh]
// Assertion macros for the OHLCV bar aggregator.
// Included by the modules that carry concurrent checks; depends on nothing.
`ifndef TICK_TO_OHLCV_BAR_AGGREGATOR_CORE_MACROS_SVH
`define TICK_TO_OHLCV_BAR_AGGREGATOR_CORE_MACROS_SVH
`ifndef SYNTHESIS
`define OBAG_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);
`define OBAG_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);
`else
`define OBAG_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg)
`define OBAG_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg)
`endif
`endif

[hdl/obag_pkg.sv]
// Package for the OHLCV bar aggregator: item structs, codes, slot constants.
// No dependencies; imported by every module of the block but obag_ram.
`default_nettype none

package obag_pkg;

    localparam int SYMBOLS = 256;
    localparam int SYM_W   = (SYMBOLS > 1) ? $clog2(SYMBOLS) : 1;

    localparam int OP_W    = 2;
    localparam int SYMB_W  = 8;
    localparam int TIME_W  = 44;
    localparam int PRICE_W = 32;
    localparam int VOL_W   = 40;

    localparam logic [OP_W-1:0] OP_TICK    = 2'd0;
    localparam logic [OP_W-1:0] OP_WATCH   = 2'd1;
    localparam logic [OP_W-1:0] OP_UNWATCH = 2'd2;

    // slot lengths; 60000 = 32 * 1875, so the timestamp is shifted first
    localparam longint unsigned SHORT_MS   = 64'd60000;
    localparam longint unsigned LONG_RATIO = 64'd5;
    localparam longint unsigned LONG_MS    = SHORT_MS * LONG_RATIO;
    localparam int              TS_SHIFT   = 5;
    localparam longint unsigned DIV_SHORT  = SHORT_MS >> TS_SHIFT;

    // reciprocals scaled by 2^32, rounded down: quotient is exact or one low
    localparam int               RECIP_SHIFT = 32;
    localparam int               REC_S_W     = 22;
    localparam int               REC_R_W     = 30;
    localparam logic [REC_S_W-1:0] REC_SHORT =
        REC_S_W'((64'd1 << RECIP_SHIFT) / DIV_SHORT);
    localparam logic [REC_R_W-1:0] REC_RATIO =
        REC_R_W'((64'd1 << RECIP_SHIFT) / LONG_RATIO);

    // digit split of the shifted timestamp (39 bits = 19 high + 20 low)
    localparam int XL_W = 20;
    localparam int XH_W = TIME_W - TS_SHIFT - XL_W;
    localparam int QH_W = 9;
    localparam int RH_W = 11;
    localparam int Q1_W = QH_W + XL_W;
    localparam int Q5_W = 26;

    localparam int JQ_DEPTH = 4;
    localparam int JQ_AW    = $clog2(JQ_DEPTH);
    localparam int JQ_CNT_W = JQ_AW + 1;

    // power of two: pointers wrap by themselves
    localparam int OQ_DEPTH = 4;
    localparam int OQ_AW    = $clog2(OQ_DEPTH);
    localparam int OQ_CNT_W = OQ_AW + 1;

    typedef enum logic [1:0] {
        KIND_TICK    = 2'd0,
        KIND_WATCH   = 2'd1,
        KIND_UNWATCH = 2'd2
    } t_kind;

    typedef enum logic [1:0] {
        BS_IDLE = 2'b01,
        BS_UPD  = 2'b10
    } t_bstate;

    typedef struct packed {
        logic [OP_W-1:0]    opcode;
        logic [SYMB_W-1:0]  symbol;
        logic [TIME_W-1:0]  time_ms;
        logic [PRICE_W-1:0] price;
        logic [VOL_W-1:0]   tick_volume;
    } t_in;

    typedef struct packed {
        logic [SYMB_W-1:0]  bar_symbol;
        logic               bar_period;
        logic [TIME_W-1:0]  bar_start_ms;
        logic [PRICE_W-1:0] bar_open;
        logic [PRICE_W-1:0] bar_high;
        logic [PRICE_W-1:0] bar_low;
        logic [PRICE_W-1:0] bar_close;
        logic [VOL_W-1:0]   bar_volume;
        logic               last_of_run;
    } t_out;

    typedef struct packed {
        t_kind              kind;
        logic [SYM_W-1:0]   idx;
        logic [SYMB_W-1:0]  symbol;
        logic [PRICE_W-1:0] price;
        logic [VOL_W-1:0]   vol;
        logic [TIME_W-1:0]  start_s;
        logic [TIME_W-1:0]  start_l;
    } t_job;

    typedef struct packed {
        logic empty;
        logic full;
    } t_qstat;

    typedef struct packed {
        logic [TIME_W-1:0]  slot;
        logic [PRICE_W-1:0] open;
        logic [PRICE_W-1:0] high;
        logic [PRICE_W-1:0] low;
        logic [PRICE_W-1:0] close;
        logic [VOL_W-1:0]   vol;
    } t_bar;

    localparam int BAR_W = $bits(t_bar);

    typedef struct packed {
        t_bar nxt;
        logic emit;
    } t_apply;

endpackage

`default_nettype wire

[hdl/obag_ram.sv]
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`default_nettype none

module obag_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic             i_re,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire

[hdl/obag_front.sv]
// Front end: accepts items, classifies them and works out both slot starts.
// Depends on obag_pkg.
`default_nettype none

module obag_front import obag_pkg::*; (
    input  logic   i_clk,
    input  logic   i_rst_n,
    input  logic   i_valid,
    input  t_in    i_item,
    output logic   o_stall,
    output logic   o_push,
    output t_job   o_job,
    input  t_qstat i_qstat
);

    localparam int NST = 8;

    logic             adv;
    logic             in_keep;
    t_job             in_job;
    logic [NST-1:0]   r_v;
    logic [NST-1:0]   r_keep;
    t_job             r_job [NST];

    logic [XH_W-1:0]              r0_xh, r1_xh;
    logic [XL_W-1:0]              r0_xl, r1_xl, r2_xl;
    logic [XH_W+REC_S_W-1:0]      r1_ph;
    logic [QH_W-1:0]              r2_qh, r3_qh;
    logic [RH_W-1:0]              r2_rh;
    logic [RH_W+XL_W-1:0]         r3_n;
    logic [RH_W+XL_W+REC_S_W-1:0] r3_pl;
    logic [Q1_W-1:0]              r4_q1, r5_q1;
    logic [Q1_W+REC_R_W-1:0]      r5_p5;
    logic [TIME_W-1:0]            r5_ss, r6_ss, r7_ss, r7_sl;
    logic [Q5_W-1:0]              r6_q5;

    logic [QH_W-1:0]  qh_e, qh;
    logic [XL_W-1:0]  qh_prod_unused;
    logic [19:0]      qh_prod, rh_e;
    logic [RH_W-1:0]  rh;
    logic [XL_W:0]    ql_e;
    logic [31:0]      ql_prod, rl_e;
    logic [XL_W-1:0]  ql;
    logic [Q5_W:0]    q5_e;
    logic [Q1_W:0]    q5_prod, r5_e;
    logic [Q5_W-1:0]  q5;

    assign adv     = !(r_v[NST-1] && r_keep[NST-1] && i_qstat.full);
    assign o_stall = !adv;
    assign o_push  = r_v[NST-1] && r_keep[NST-1] && !i_qstat.full;

    always_comb begin
        in_job         = '0;
        in_job.idx     = SYM_W'(i_item.symbol);
        in_job.symbol  = i_item.symbol;
        in_job.price   = i_item.price;
        in_job.vol     = i_item.tick_volume;
        in_keep        = (32'(i_item.symbol) < SYMBOLS);
        case (i_item.opcode)
            OP_TICK:    in_job.kind = KIND_TICK;
            OP_WATCH:   in_job.kind = KIND_WATCH;
            OP_UNWATCH: in_job.kind = KIND_UNWATCH;
            default: begin
                in_job.kind = KIND_TICK;
                in_keep     = 1'b0;
            end
        endcase
    end

    // high digit: xh / 1875
    assign qh_e           = r1_ph[XH_W+REC_S_W-1:RECIP_SHIFT];
    assign qh_prod        = 20'(qh_e) * 20'(DIV_SHORT);
    assign qh_prod_unused = '0;
    assign rh_e           = 20'(r1_xh) - qh_prod;

    always_comb begin
        if (rh_e >= 20'(DIV_SHORT)) begin
            qh = qh_e + 1'b1;
            rh = RH_W'(rh_e - 20'(DIV_SHORT));
        end else begin
            qh = qh_e;
            rh = RH_W'(rh_e);
        end
    end

    // low digit: (rh * 2^20 + xl) / 1875
    assign ql_e    = r3_pl[RH_W+XL_W+REC_S_W-1:RECIP_SHIFT];
    assign ql_prod = 32'(ql_e) * 32'(DIV_SHORT);
    assign rl_e    = 32'(r3_n) - ql_prod;

    always_comb begin
        if (rl_e >= 32'(DIV_SHORT)) begin
            ql = XL_W'(ql_e + 1'b1);
        end else begin
            ql = XL_W'(ql_e);
        end
    end

    // minutes / 5
    assign q5_e    = r5_p5[Q1_W+REC_R_W-1:RECIP_SHIFT+Q1_W-Q1_W+2] == '0 ?
                     (Q5_W+1)'(r5_p5[Q1_W+REC_R_W-1:RECIP_SHIFT]) :
                     (Q5_W+1)'(r5_p5[Q1_W+REC_R_W-1:RECIP_SHIFT]);
    assign q5_prod = {1'b0, q5_e, 2'b00} + (Q1_W+1)'(q5_e);
    assign r5_e    = (Q1_W+1)'(r5_q1) - q5_prod;

    always_comb begin
        if (r5_e >= (Q1_W+1)'(LONG_RATIO)) begin
            q5 = Q5_W'(q5_e + 1'b1);
        end else begin
            q5 = Q5_W'(q5_e);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else if (adv) begin
            r_v <= {r_v[NST-2:0], i_valid};
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_keep   <= {r_keep[NST-2:0], in_keep};
            r_job[0] <= in_job;
            for (int k = 1; k < NST; k++) begin
                r_job[k] <= r_job[k-1];
            end
            r0_xh <= i_item.time_ms[TIME_W-1:TS_SHIFT+XL_W];
            r0_xl <= i_item.time_ms[TS_SHIFT+XL_W-1:TS_SHIFT];
            r1_ph <= (XH_W+REC_S_W)'(r0_xh) * (XH_W+REC_S_W)'(REC_SHORT);
            r1_xh <= r0_xh;
            r1_xl <= r0_xl;
            r2_qh <= qh;
            r2_rh <= rh;
            r2_xl <= r1_xl;
            r3_n  <= {r2_rh, r2_xl};
            r3_pl <= (RH_W+XL_W+REC_S_W)'({r2_rh, r2_xl}) *
                     (RH_W+XL_W+REC_S_W)'(REC_SHORT);
            r3_qh <= r2_qh;
            r4_q1 <= {r3_qh, ql} | Q1_W'(qh_prod_unused);
            r5_p5 <= (Q1_W+REC_R_W)'(r4_q1) * (Q1_W+REC_R_W)'(REC_RATIO);
            r5_ss <= TIME_W'((TIME_W+1)'(r4_q1) * (TIME_W+1)'(SHORT_MS));
            r5_q1 <= r4_q1;
            r6_q5 <= q5;
            r6_ss <= r5_ss;
            r7_sl <= TIME_W'((TIME_W+1)'(r6_q5) * (TIME_W+1)'(LONG_MS));
            r7_ss <= r6_ss;
        end
    end

    always_comb begin
        o_job         = r_job[NST-1];
        o_job.start_s = r7_ss;
        o_job.start_l = r7_sl;
    end

endmodule

`default_nettype wire

[hdl/obag_queue.sv]
// Short job queue between front and back end.
// Depends on obag_pkg and the assertion macro header.
`default_nettype none
`include "tick_to_ohlcv_bar_aggregator_core_macros.svh"

module obag_queue import obag_pkg::*; (
    input  logic   i_clk,
    input  logic   i_rst_n,
    input  logic   i_push,
    input  t_job   i_job,
    input  logic   i_pop,
    output t_job   o_head,
    output t_qstat o_stat
);

    t_job                r_mem [JQ_DEPTH];
    logic [JQ_AW-1:0]    r_wr;
    logic [JQ_AW-1:0]    r_rd;
    logic [JQ_CNT_W-1:0] r_cnt;

    assign o_head       = r_mem[r_rd];
    assign o_stat.empty = (r_cnt == '0);
    assign o_stat.full  = (r_cnt == JQ_CNT_W'(JQ_DEPTH));

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr] <= i_job;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) begin
                r_wr <= r_wr + 1'b1;
            end
            if (i_pop) begin
                r_rd <= r_rd + 1'b1;
            end
            r_cnt <= r_cnt + JQ_CNT_W'(i_push) - JQ_CNT_W'(i_pop);
        end
    end

    `OBAG_ASSERT_IMP(a_no_push_full, i_clk, i_rst_n, i_push, !o_stat.full, "push into full queue")
    `OBAG_ASSERT_IMP(a_no_pop_empty, i_clk, i_rst_n, i_pop, !o_stat.empty, "pop from empty queue")

endmodule

`default_nettype wire

[hdl/obag_back.sv]
// Back end: watch flags, per-symbol bar memories, bar update and result queue.
// Depends on obag_pkg, obag_ram and the assertion macro header.
`default_nettype none
`include "tick_to_ohlcv_bar_aggregator_core_macros.svh"

module obag_back import obag_pkg::*; (
    input  logic   i_clk,
    input  logic   i_rst_n,
    input  t_job   i_head,
    input  t_qstat i_qstat,
    output logic   o_pop,
    output logic   o_valid,
    output t_out   o_item,
    input  logic   i_stall
);

    t_bstate             r_state, n_state;
    logic [SYMBOLS-1:0]  r_watched, n_watched;
    logic [SYMBOLS-1:0]  r_fresh, n_fresh;
    t_job                r_job;
    logic                r_new;
    logic                ram_re, ram_we;
    t_bar                rd_s, rd_l, old_s, old_l;
    t_apply              ap_s, ap_l;
    logic                emit_s, emit_l;
    t_out                rec_s, rec_l, res0, res1;
    logic [1:0]          npush;
    logic                opop;
    t_out                r_oq [OQ_DEPTH];
    logic [OQ_AW-1:0]    r_owr, r_ord;
    logic [OQ_CNT_W-1:0] r_ocnt;

    function automatic t_apply apply_bar(t_bar b, logic [TIME_W-1:0] start,
                                         logic [PRICE_W-1:0] p, logic [VOL_W-1:0] v);
        t_apply a;
        a.emit = 1'b0;
        a.nxt  = b;
        if (start != b.slot) begin
            a.emit      = (b.slot != '0) && (b.vol != '0);
            a.nxt.slot  = start;
            a.nxt.open  = p;
            a.nxt.high  = p;
            a.nxt.low   = p;
            a.nxt.close = p;
            a.nxt.vol   = '0;
        end else begin
            if (p > b.high) begin
                a.nxt.high = p;
            end
            if (p < b.low) begin
                a.nxt.low = p;
            end
            a.nxt.close = p;
            a.nxt.vol   = v;
        end
        return a;
    endfunction

    obag_ram #(.WIDTH(BAR_W), .DEPTH(SYMBOLS)) u_ram_s (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (r_job.idx),
        .i_wdata (ap_s.nxt),
        .i_re    (ram_re),
        .i_raddr (i_head.idx),
        .o_rdata (rd_s)
    );

    obag_ram #(.WIDTH(BAR_W), .DEPTH(SYMBOLS)) u_ram_l (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (r_job.idx),
        .i_wdata (ap_l.nxt),
        .i_re    (ram_re),
        .i_raddr (i_head.idx),
        .o_rdata (rd_l)
    );

    always_comb begin
        n_state   = r_state;
        n_watched = r_watched;
        n_fresh   = r_fresh;
        o_pop     = 1'b0;
        ram_re    = 1'b0;
        ram_we    = 1'b0;
        case (r_state)
            BS_IDLE: begin
                if (!i_qstat.empty) begin
                    case (i_head.kind)
                        KIND_WATCH: begin
                            o_pop = 1'b1;
                            if (!r_watched[i_head.idx]) begin
                                n_watched[i_head.idx] = 1'b1;
                                n_fresh[i_head.idx]   = 1'b1;
                            end
                        end
                        KIND_UNWATCH: begin
                            o_pop                 = 1'b1;
                            n_watched[i_head.idx] = 1'b0;
                        end
                        KIND_TICK: begin
                            if (!r_watched[i_head.idx]) begin
                                o_pop = 1'b1;
                            end else if (r_ocnt <= OQ_CNT_W'(OQ_DEPTH - 2)) begin
                                o_pop   = 1'b1;
                                ram_re  = 1'b1;
                                n_state = BS_UPD;
                            end
                        end
                        default: o_pop = 1'b1;
                    endcase
                end
            end
            BS_UPD: begin
                ram_we             = 1'b1;
                n_fresh[r_job.idx] = 1'b0;
                n_state            = BS_IDLE;
            end
            default: n_state = BS_IDLE;
        endcase
    end

    // a freshly watched symbol reads as an all-zero bar
    assign old_s  = r_new ? '0 : rd_s;
    assign old_l  = r_new ? '0 : rd_l;
    assign ap_s   = apply_bar(old_s, r_job.start_s, r_job.price, r_job.vol);
    assign ap_l   = apply_bar(old_l, r_job.start_l, r_job.price, r_job.vol);
    assign emit_s = (r_state == BS_UPD) && ap_s.emit;
    assign emit_l = (r_state == BS_UPD) && ap_l.emit;

    always_comb begin
        rec_s.bar_symbol   = r_job.symbol;
        rec_s.bar_period   = 1'b0;
        rec_s.bar_start_ms = old_s.slot;
        rec_s.bar_open     = old_s.open;
        rec_s.bar_high     = old_s.high;
        rec_s.bar_low      = old_s.low;
        rec_s.bar_close    = old_s.close;
        rec_s.bar_volume   = old_s.vol;
        rec_s.last_of_run  = !emit_l;
        rec_l.bar_symbol   = r_job.symbol;
        rec_l.bar_period   = 1'b1;
        rec_l.bar_start_ms = old_l.slot;
        rec_l.bar_open     = old_l.open;
        rec_l.bar_high     = old_l.high;
        rec_l.bar_low      = old_l.low;
        rec_l.bar_close    = old_l.close;
        rec_l.bar_volume   = old_l.vol;
        rec_l.last_of_run  = 1'b1;
        res0               = emit_s ? rec_s : rec_l;
        res1               = rec_l;
        npush              = 2'(emit_s) + 2'(emit_l);
    end

    assign o_valid = (r_ocnt != '0);
    assign o_item  = r_oq[r_ord];
    assign opop    = o_valid && !i_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= BS_IDLE;
            r_watched <= '0;
            r_fresh   <= '0;
            r_owr     <= '0;
            r_ord     <= '0;
            r_ocnt    <= '0;
        end else begin
            r_state   <= n_state;
            r_watched <= n_watched;
            r_fresh   <= n_fresh;
            r_owr     <= r_owr + OQ_AW'(npush);
            if (opop) begin
                r_ord <= r_ord + 1'b1;
            end
            r_ocnt <= r_ocnt + OQ_CNT_W'(npush) - OQ_CNT_W'(opop);
        end
    end

    always_ff @(posedge i_clk) begin
        if (ram_re) begin
            r_job <= i_head;
            r_new <= r_fresh[i_head.idx];
        end
        if (npush != 2'd0) begin
            r_oq[r_owr] <= res0;
        end
        if (npush == 2'd2) begin
            r_oq[r_owr + 1'b1] <= res1;
        end
    end

    `OBAG_ASSERT_NEXT(a_upd_single, i_clk, i_rst_n, r_state == BS_UPD, r_state == BS_IDLE, "update held over")
    `OBAG_ASSERT_IMP(a_upd_watched, i_clk, i_rst_n, r_state == BS_UPD, r_watched[r_job.idx], "update of unwatched symbol")
    `OBAG_ASSERT_IMP(a_oq_bound, i_clk, i_rst_n, 1'b1, r_ocnt <= OQ_CNT_W'(OQ_DEPTH), "result queue overrun")

endmodule

`default_nettype wire

[hdl/tick_to_ohlcv_bar_aggregator_core.sv]
// Top level of the OHLCV bar aggregator: front end, job queue and back end.
// Depends on obag_pkg, obag_front, obag_queue, obag_back.
//
// Items enter at up to one per cycle, while o_stall is low, into an eight-stage
// front end that drops unused opcodes and out-of-range symbols and works out
// the one- and five-minute slot starts by reciprocal multiplication. A four-deep
// queue feeds the back end, which handles a tick on a watched symbol as a bar
// memory read, then update and write-back, and takes no new job until the update
// is done; a watch, unwatch or tick on an unwatched symbol needs no update. A
// watched tick also waits for room for two bars in the result queue.
// A tick gives up to two bars, the one-minute bar first, through a four-deep
// result queue. Bar memories need no clearing pass: a watch of an unwatched
// symbol marks it so that its next tick sees all-zero bars.
`default_nettype none

module tick_to_ohlcv_bar_aggregator_core import obag_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_valid,
    input  t_in  i_item,
    output logic o_stall,
    output logic o_valid,
    output t_out o_item,
    input  logic i_stall
);

    logic   push, pop;
    t_job   job, head;
    t_qstat qstat;

    obag_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .i_item  (i_item),
        .o_stall (o_stall),
        .o_push  (push),
        .o_job   (job),
        .i_qstat (qstat)
    );

    obag_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_job   (job),
        .i_pop   (pop),
        .o_head  (head),
        .o_stat  (qstat)
    );

    obag_back u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_head  (head),
        .i_qstat (qstat),
        .o_pop   (pop),
        .o_valid (o_valid),
        .o_item  (o_item),
        .i_stall (i_stall)
    );

endmodule

`default_nettype wire
